FILE: hw/rtl/srv_pkg.sv
// Package for the Snell refraction vector unit: shared constants, payload structs
// and the single-step square root and division functions used by the pipeline.
// No dependencies.
`default_nettype none

package srv_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    // valid index of the word that enters the second square root chain
    localparam int SQ2_VLD    = 4 + (SQRT_STEPS + 1) + (DIV_STEPS + 1) + 5;
    localparam int LATENCY    = SQ2_VLD + (SQRT_STEPS + 1) + 2;

    localparam logic signed [63:0] ONE_Q56 = 64'sh0100_0000_0000_0000;
    localparam logic signed [63:0] ONE_Q48 = 64'sh0001_0000_0000_0000;
    localparam logic signed [23:0] OUT_MAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] OUT_MIN = 24'sh80_0000;

    typedef struct packed {
        logic [63:0] rad;
        logic [63:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [2:0][15:0] nrm;
        logic [15:0]      eta;
        logic             zero;
    } t_ray;

    typedef struct packed {
        logic [31:0]      len;
        logic [2:0][61:0] rem;
        logic [2:0][30:0] quo;
        logic [2:0]       neg;
        logic [2:0][15:0] nrm;
        logic [15:0]      eta;
        logic             zero;
    } t_div;

    typedef struct packed {
        logic [2:0][36:0] tan;
        logic [2:0][15:0] nrm;
        logic [15:0]      eta;
        logic             ok;
    } t_tail;

    // one restoring square root step, trial bit at 2^pos
    function automatic t_sqrt sqrt_step(input t_sqrt st, input logic [5:0] pos);
        logic [63:0] bval;
        logic [63:0] trial;
        t_sqrt       nx;
        bval  = 64'd1 << pos;
        trial = st.root + bval;
        if (st.rad >= trial) begin
            nx.rad  = st.rad - trial;
            nx.root = (st.root >> 1) + bval;
        end else begin
            nx.rad  = st.rad;
            nx.root = st.root >> 1;
        end
        return nx;
    endfunction

    // one restoring division step on all three lanes, quotient bit pos
    function automatic t_div div_step(input t_div d, input logic [4:0] pos);
        logic [61:0] trial;
        t_div        nx;
        nx    = d;
        trial = {30'd0, d.len} << pos;
        for (int k = 0; k < 3; k++) begin
            if (d.rem[k] >= trial) begin
                nx.rem[k]      = d.rem[k] - trial;
                nx.quo[k][pos] = 1'b1;
            end
        end
        return nx;
    endfunction

    // left shift that brings the largest magnitude into [2^30, 2^31]
    function automatic logic [4:0] norm_shift(input logic [31:0] m);
        logic [4:0] sh;
        sh = '0;
        for (int i = 0; i < 31; i++) begin
            if (m[i]) begin
                sh = 5'(30 - i);
            end
        end
        return sh;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/snell_refraction_vector_unit.sv
// Snell refraction vector unit: normalizes the incident ray, forms the Snell
// discriminant and the refracted direction in a fully pipelined datapath.
// Depends on srv_pkg.
//
//  channel   | handshake               | words
//  ----------+-------------------------+-----------------------------------------
//  ray in    | i_start, o_busy         | i_incident_x/y/z, i_normal_x/y/z, i_eta_ratio
//  result    | o_done (strobe)         | o_refracted_x/y/z, o_refraction_ok
//
// One word is taken every cycle; o_busy stays low since nothing can stall.
// The datapath holds two 32-step square root chains and a 31-step divider
// chain, one restoring step per stage.
// Reset clears only the valid chain; payload registers are not reset.
// Each result shows for one cycle with o_done; the receiver cannot hold it.
`default_nettype none

module snell_refraction_vector_unit
    import srv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic signed [31:0] i_incident_x,
    input  wire logic signed [31:0] i_incident_y,
    input  wire logic signed [31:0] i_incident_z,
    input  wire logic signed [15:0] i_normal_x,
    input  wire logic signed [15:0] i_normal_y,
    input  wire logic signed [15:0] i_normal_z,
    input  wire logic        [15:0] i_eta_ratio,
    output logic                    o_done,
    output logic signed [23:0]      o_refracted_x,
    output logic signed [23:0]      o_refracted_y,
    output logic signed [23:0]      o_refracted_z,
    output logic                    o_refraction_ok
);

    // valid chain: bit s is set when a word has passed s+1 register stages
    logic [LATENCY-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], i_start};
        end
    end

    // ---- front end: magnitudes, normalizing shift, squares ----
    logic [2:0][31:0] w_inc;
    logic [2:0][31:0] w_mag;
    logic [31:0]      w_m01;
    logic [31:0]      w_max;

    assign w_inc = {i_incident_z, i_incident_y, i_incident_x};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = w_inc[k][31] ? (~w_inc[k] + 32'd1) : w_inc[k];
        end
    end

    t_ray        r_p1;
    t_ray        r_p2;
    logic [4:0]  r_p2_sh;
    t_ray        r_p3;
    t_ray        r_p4;
    logic [63:0] r_p4_sq [3];

    assign w_m01 = (r_p1.mag[0] > r_p1.mag[1]) ? r_p1.mag[0] : r_p1.mag[1];
    assign w_max = (w_m01 > r_p1.mag[2]) ? w_m01 : r_p1.mag[2];

    // ---- square root of the sum of squares, then three dividers ----
    t_sqrt r_sq1     [SQRT_STEPS+1];
    t_ray  r_sq1_pay [SQRT_STEPS+1];
    t_div  r_dv      [DIV_STEPS+1];

    // ---- dot product and discriminant ----
    logic        [31:0] w_q  [3];
    logic signed [31:0] w_u  [3];
    logic signed [47:0] w_un [3];

    logic signed [31:0] r_d1_u  [3];
    logic signed [47:0] r_d1_un [3];
    logic [2:0][15:0]   r_d1_nrm;
    logic [15:0]        r_d1_eta;
    logic               r_d1_zero;

    logic signed [47:0] w_dsum;
    logic signed [33:0] r_d2_dt;
    logic signed [31:0] r_d2_u [3];
    logic [2:0][15:0]   r_d2_nrm;
    logic [15:0]        r_d2_eta;
    logic               r_d2_zero;

    logic signed [31:0] w_d28;
    logic signed [63:0] r_d3_dsq;
    logic [31:0]        r_d3_eta2;
    logic signed [49:0] r_d3_ndt [3];
    logic signed [31:0] r_d3_u   [3];
    logic [2:0][15:0]   r_d3_nrm;
    logic [15:0]        r_d3_eta;
    logic               r_d3_zero;

    logic signed [63:0] w_kdiff;
    logic signed [31:0] r_d4_k;
    logic signed [36:0] r_d4_t [3];
    logic [31:0]        r_d4_eta2;
    logic [2:0][15:0]   r_d4_nrm;
    logic [15:0]        r_d4_eta;
    logic               r_d4_zero;

    logic signed [32:0] w_eta2s;
    logic signed [63:0] r_d5_prod;
    logic signed [36:0] r_d5_t [3];
    logic [2:0][15:0]   r_d5_nrm;
    logic [15:0]        r_d5_eta;
    logic               r_d5_zero;

    logic signed [63:0] w_dsc;
    logic               w_pos;

    t_sqrt r_sq2     [SQRT_STEPS+1];
    t_tail r_sq2_pay [SQRT_STEPS+1];

    // ---- output products and saturation ----
    logic signed [32:0] w_s;
    logic signed [16:0] w_eta_s;
    logic signed [53:0] r_e1_pe [3];
    logic signed [48:0] r_e1_ps [3];
    logic               r_e1_ok;

    logic signed [55:0] w_r   [3];
    logic signed [29:0] w_f   [3];
    logic signed [23:0] w_sat [3];

    logic signed [23:0] r_out [3];
    logic               r_ok;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_q[k] = {1'b0, r_dv[DIV_STEPS].quo[k]};
            w_u[k] = r_dv[DIV_STEPS].neg[k] ? -$signed(w_q[k]) : $signed(w_q[k]);
            w_un[k] = 48'(w_u[k]) * 48'($signed(r_dv[DIV_STEPS].nrm[k]));
        end
    end

    assign w_dsum  = r_d1_un[0] + r_d1_un[1] + r_d1_un[2];
    assign w_d28   = r_d2_dt[33:2];
    assign w_kdiff = ONE_Q56 - r_d3_dsq;
    assign w_eta2s = $signed({1'b0, r_d4_eta2});
    assign w_dsc   = ONE_Q48 - r_d5_prod;
    assign w_pos   = !w_dsc[63] && (w_dsc != 64'sd0);
    assign w_s     = $signed({1'b0, r_sq2[SQRT_STEPS].root[31:0]});
    assign w_eta_s = $signed({1'b0, r_sq2_pay[SQRT_STEPS].eta});

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_r[k] = 56'(r_e1_pe[k]) - (56'(r_e1_ps[k]) <<< 4);
            w_f[k] = w_r[k][55:26];
            if (w_f[k] > 30'(OUT_MAX)) begin
                w_sat[k] = OUT_MAX;
            end else if (w_f[k] < 30'(OUT_MIN)) begin
                w_sat[k] = OUT_MIN;
            end else begin
                w_sat[k] = w_f[k][23:0];
            end
        end
    end

    // payload pipeline: advance every cycle, validity rides in r_vld
    always_ff @(posedge i_clk) begin
        // input capture
        r_p1.mag  <= w_mag;
        r_p1.neg  <= {i_incident_z[31], i_incident_y[31], i_incident_x[31]};
        r_p1.nrm  <= {i_normal_z, i_normal_y, i_normal_x};
        r_p1.eta  <= i_eta_ratio;
        r_p1.zero <= 1'b0;

        // find the normalizing shift
        r_p2.mag  <= r_p1.mag;
        r_p2.neg  <= r_p1.neg;
        r_p2.nrm  <= r_p1.nrm;
        r_p2.eta  <= r_p1.eta;
        r_p2.zero <= (w_max == 32'd0);
        r_p2_sh   <= norm_shift(w_max);

        // apply it; the largest component lands in [2^30, 2^31]
        r_p3.neg  <= r_p2.neg;
        r_p3.nrm  <= r_p2.nrm;
        r_p3.eta  <= r_p2.eta;
        r_p3.zero <= r_p2.zero;
        for (int k = 0; k < 3; k++) begin
            r_p3.mag[k] <= r_p2.mag[k] << r_p2_sh;
        end

        r_p4 <= r_p3;
        for (int k = 0; k < 3; k++) begin
            r_p4_sq[k] <= 64'(r_p3.mag[k]) * 64'(r_p3.mag[k]);
        end

        // length: floor square root, one bit per stage
        r_sq1[0].rad  <= r_p4_sq[0] + r_p4_sq[1] + r_p4_sq[2];
        r_sq1[0].root <= '0;
        r_sq1_pay[0]  <= r_p4;
        for (int i = 0; i < SQRT_STEPS; i++) begin
            r_sq1[i+1]     <= sqrt_step(r_sq1[i], 6'(62 - 2 * i));
            r_sq1_pay[i+1] <= r_sq1_pay[i];
        end

        // unit vector: (mag << 30) / length, one quotient bit per stage
        r_dv[0].len <= r_sq1[SQRT_STEPS].root[31:0];
        for (int k = 0; k < 3; k++) begin
            r_dv[0].rem[k] <= {r_sq1_pay[SQRT_STEPS].mag[k], 30'd0};
        end
        r_dv[0].quo  <= '0;
        r_dv[0].neg  <= r_sq1_pay[SQRT_STEPS].neg;
        r_dv[0].nrm  <= r_sq1_pay[SQRT_STEPS].nrm;
        r_dv[0].eta  <= r_sq1_pay[SQRT_STEPS].eta;
        r_dv[0].zero <= r_sq1_pay[SQRT_STEPS].zero;
        for (int j = 0; j < DIV_STEPS; j++) begin
            r_dv[j+1] <= div_step(r_dv[j], 5'(DIV_STEPS - 1 - j));
        end

        // u_k and u_k * n_k
        for (int k = 0; k < 3; k++) begin
            r_d1_u[k]  <= w_u[k];
            r_d1_un[k] <= w_un[k];
        end
        r_d1_nrm  <= r_dv[DIV_STEPS].nrm;
        r_d1_eta  <= r_dv[DIV_STEPS].eta;
        r_d1_zero <= r_dv[DIV_STEPS].zero;

        // dot product, Q.30
        r_d2_dt   <= w_dsum[47:14];
        r_d2_u    <= r_d1_u;
        r_d2_nrm  <= r_d1_nrm;
        r_d2_eta  <= r_d1_eta;
        r_d2_zero <= r_d1_zero;

        // dt^2, eta^2 and n_k * dt side by side
        r_d3_dsq  <= 64'(w_d28) * 64'(w_d28);
        r_d3_eta2 <= 32'(r_d2_eta) * 32'(r_d2_eta);
        for (int k = 0; k < 3; k++) begin
            r_d3_ndt[k] <= 50'($signed(r_d2_nrm[k])) * 50'(r_d2_dt);
        end
        r_d3_u    <= r_d2_u;
        r_d3_nrm  <= r_d2_nrm;
        r_d3_eta  <= r_d2_eta;
        r_d3_zero <= r_d2_zero;

        // k = (1 - dt^2) in Q.24, tangent part t_k
        r_d4_k <= w_kdiff[63:32];
        for (int k = 0; k < 3; k++) begin
            r_d4_t[k] <= 37'(r_d3_u[k]) - 37'($signed(r_d3_ndt[k][49:14]));
        end
        r_d4_eta2 <= r_d3_eta2;
        r_d4_nrm  <= r_d3_nrm;
        r_d4_eta  <= r_d3_eta;
        r_d4_zero <= r_d3_zero;

        r_d5_prod <= 64'(w_eta2s) * 64'(r_d4_k);
        r_d5_t    <= r_d4_t;
        r_d5_nrm  <= r_d4_nrm;
        r_d5_eta  <= r_d4_eta;
        r_d5_zero <= r_d4_zero;

        // discriminant; drop to zero radicand when not strictly positive
        r_sq2[0].rad  <= w_pos ? w_dsc : 64'sd0;
        r_sq2[0].root <= '0;
        for (int k = 0; k < 3; k++) begin
            r_sq2_pay[0].tan[k] <= r_d5_t[k];
        end
        r_sq2_pay[0].nrm <= r_d5_nrm;
        r_sq2_pay[0].eta <= r_d5_eta;
        r_sq2_pay[0].ok  <= w_pos && !r_d5_zero;
        for (int i = 0; i < SQRT_STEPS; i++) begin
            r_sq2[i+1]     <= sqrt_step(r_sq2[i], 6'(62 - 2 * i));
            r_sq2_pay[i+1] <= r_sq2_pay[i];
        end

        // eta * t_k and n_k * sqrt(D)
        for (int k = 0; k < 3; k++) begin
            r_e1_pe[k] <= 54'(w_eta_s) * 54'($signed(r_sq2_pay[SQRT_STEPS].tan[k]));
            r_e1_ps[k] <= 49'($signed(r_sq2_pay[SQRT_STEPS].nrm[k])) * 49'(w_s);
        end
        r_e1_ok <= r_sq2_pay[SQRT_STEPS].ok;

        // result register: zero the direction on reflection or zero input
        for (int k = 0; k < 3; k++) begin
            r_out[k] <= r_e1_ok ? w_sat[k] : 24'sd0;
        end
        r_ok <= r_e1_ok && r_vld[LATENCY-2];
    end

    assign o_busy          = 1'b0;
    assign o_done          = r_vld[LATENCY-1];
    assign o_refracted_x   = r_out[0];
    assign o_refracted_y   = r_out[1];
    assign o_refracted_z   = r_out[2];
    assign o_refraction_ok = r_ok;

    // a result strobe always traces back to a matching start
    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LATENCY))
        else $error("result word without a matching start");

    // the ok flag only shows on a result word
    a_ok_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_refraction_ok |-> o_done)
        else $error("refraction_ok outside a result word");

    // a failed refraction carries a zero direction
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_refraction_ok) |->
            (o_refracted_x == 24'sd0 && o_refracted_y == 24'sd0 &&
             o_refracted_z == 24'sd0))
        else $error("nonzero direction on reflection or zero incident");

    // a refracting word enters the second root with a positive radicand
    a_ok_radicand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[SQ2_VLD] && r_sq2_pay[0].ok) |-> (r_sq2[0].rad != 64'd0))
        else $error("refraction flagged with zero discriminant");

endmodule

`default_nettype wire
